>>> sv/mlfqs_pkg.sv
// Package for the MLFQS priority engine: fixed-point constants, opcodes, register
// indices, the thread table row type and the sequencer state type. No dependencies.
`default_nettype none
package mlfqs_pkg;

    localparam int THREADS   = 64;
    localparam int TID_W     = 6;
    localparam int SLICE_W   = 2;      // every fourth tick recomputes priorities
    localparam int FP_SHIFT  = 14;     // 17.14 fixed point, one is 16384
    localparam int LOAD_KEEP = 59;
    localparam int LOAD_DIV  = 60;
    localparam int DIV_STEPS = 64;

    // For any x below 2**26, x / 60 truncated equals (x * LOAD_RECIP) >> RECIP_SHIFT.
    localparam logic [26:0] LOAD_RECIP  = 27'd71582789;
    localparam int          RECIP_SHIFT = 32;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_NICE = 2'd1,
        OP_CHILD = 2'd2,
        OP_READ = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_ENABLE = 2'd0,
        REG_PRI_MAX = 2'd1,
        REG_PRI_MIN = 2'd2,
        REG_TPS = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] rc;
        logic signed [5:0]  nice;
        logic [5:0]         pri;
    } row_t;

    typedef enum logic [4:0] {
        S_IDLE, S_TK_RD, S_TK_WR, S_MOD_GO, S_MOD_WAIT,
        S_LA1_GO, S_LA1_WAIT, S_LA2_GO, S_LA2_WAIT, S_CO_GO, S_CO_WAIT,
        S_DC_RD, S_DC_MUL, S_DC_WR, S_SLICE_CHK, S_PR_RD, S_PR_WR,
        S_NC_RD, S_NC_WR, S_CH_RD, S_CH_WR, S_RO_RD, S_RO_MUL, S_RO_OUT
    } state_t;

endpackage
`default_nettype wire

>>> sv/mlfqs_priority_engine.sv
// Top level of the MLFQS priority engine: thread table memory, shared
// bit-serial divider, sequencer and APB registers. Uses mlfqs_pkg.
// A read goes straight to the readout; set nice and create child first read and
// write the row. A tick with MLFQS off only counts; on, it adds to an active running
// thread's recent_cpu and runs the divider's modulo check against ticks_per_second.
// Once per second it adds the load average, coefficient divide and decay sweep; every
// fourth tick it adds the priority sweep. The next request is taken only once the
// result registers. Reset clears control state and table valid bits, loads defaults.
`default_nettype none
module mlfqs_priority_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // op[1:0], thread_id[7:2], parent_id[13:8], nice_value[19:14],
    // start_priority[25:20], running_active[26], ready_count[33:27]
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // priority_res[5:0], nice_out[11:6], recent_cpu_x100[36:12],
    // load_avg_x100[49:37]
    output logic [55:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int TW = mlfqs_pkg::TID_W;

    mlfqs_pkg::state_t state_reg, state_next;

    // configuration
    logic       en_reg;
    logic [5:0] pmax_reg, pmin_reg;
    logic [9:0] tps_reg;

    // latched request
    logic [TW-1:0]     tid_reg, pid_reg;
    logic signed [5:0] nv_reg;
    logic [5:0]        sp_reg;
    logic [6:0]        rdy_reg;

    logic [63:0] tc_reg;
    logic [31:0] la_reg, q1_reg;
    logic [14:0] coef_reg;
    logic [TW:0] idx_reg;
    logic signed [47:0] prod_reg;
    logic signed [38:0] rc100_reg;
    logic [38:0]        la100_reg;

    // divider
    logic [34:0] div_rem_reg;
    logic [63:0] div_quo_reg;
    logic [33:0] div_den_reg;
    logic [6:0]  div_cnt_reg;
    logic        div_start;
    logic [63:0] div_a;
    logic [33:0] div_b;
    logic [34:0] div_trial;
    logic        div_ge;

    // reciprocal multiply for the divisions by 60
    logic [25:0] rcp_x;
    logic [52:0] rcp_prod;
    logic [20:0] rcp_q;

    // table memory
    mlfqs_pkg::row_t row_mem [mlfqs_pkg::THREADS];
    logic [mlfqs_pkg::THREADS-1:0] vld_reg;
    mlfqs_pkg::row_t rd_raw_reg, row, wd;
    logic            rd_vld_reg, re, we;
    logic [TW-1:0]   ra, wa;

    logic m_tvalid_reg;
    logic [55:0] m_tdata_reg;
    logic out_free, idx_last;

    logic [9:0] tps_eff;
    logic [6:0] rdy_sat;

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] r;
        if (v > 35'sd2147483647) r = 32'h7FFF_FFFF;
        else if (v < -35'sd2147483648) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic [5:0] pri_calc(input logic signed [31:0] rc,
                                            input logic signed [5:0] nice,
                                            input logic [5:0] pmax,
                                            input logic [5:0] pmin);
        logic signed [16:0] a;
        logic signed [18:0] p;
        logic [5:0] r;
        // Division by 4 and then by 16384, both truncating, is one division by 65536.
        a = 17'(rc >>> 16);
        if (rc < 0 && rc[15:0] != 16'd0) a = a + 17'sd1;
        p = $signed({13'd0, pmax}) - 19'(a) - (19'(nice) <<< 1);
        if (p > $signed({13'd0, pmax})) r = pmax;
        else if (p < $signed({13'd0, pmin})) r = pmin;
        else r = p[5:0];
        return r;
    endfunction

    assign pready   = 1'b1;
    assign s_tready = (state_reg == mlfqs_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign idx_last = (idx_reg[TW-1:0] == TW'(mlfqs_pkg::THREADS - 1));
    assign tps_eff  = (tps_reg == 10'd0) ? 10'd1 : tps_reg;
    assign rdy_sat  = (rdy_reg > 7'(mlfqs_pkg::THREADS)) ? 7'(mlfqs_pkg::THREADS) : rdy_reg;
    assign row      = rd_vld_reg ? rd_raw_reg : '0;

    // The load average stays at or below 64.0, so both dividends stay below 2**26.
    assign rcp_x    = (state_reg == mlfqs_pkg::S_LA1_WAIT) ?
                      26'(la_reg[20:0]) * 26'(mlfqs_pkg::LOAD_KEEP) :
                      26'(rdy_sat) << mlfqs_pkg::FP_SHIFT;
    assign rcp_prod = 53'(rcp_x) * 53'(mlfqs_pkg::LOAD_RECIP);
    assign rcp_q    = rcp_prod[52:mlfqs_pkg::RECIP_SHIFT];

    always_comb begin
        unique case (paddr[3:2])
            mlfqs_pkg::REG_ENABLE:  prdata = {31'd0, en_reg};
            mlfqs_pkg::REG_PRI_MAX: prdata = {26'd0, pmax_reg};
            mlfqs_pkg::REG_PRI_MIN: prdata = {26'd0, pmin_reg};
            mlfqs_pkg::REG_TPS:     prdata = {22'd0, tps_reg};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg   <= 1'b0;
            pmax_reg <= 6'd63;
            pmin_reg <= 6'd0;
            tps_reg  <= 10'd100;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                mlfqs_pkg::REG_ENABLE:  en_reg   <= pwdata[0];
                mlfqs_pkg::REG_PRI_MAX: pmax_reg <= pwdata[5:0];
                mlfqs_pkg::REG_PRI_MIN: pmin_reg <= pwdata[5:0];
                mlfqs_pkg::REG_TPS:     tps_reg  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mlfqs_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    unique case (mlfqs_pkg::op_t'(s_tdata[1:0]))
                        mlfqs_pkg::OP_TICK:
                            if (!en_reg) state_next = mlfqs_pkg::S_RO_RD;
                            else if (s_tdata[26]) state_next = mlfqs_pkg::S_TK_RD;
                            else state_next = mlfqs_pkg::S_MOD_GO;
                        mlfqs_pkg::OP_NICE:  state_next = mlfqs_pkg::S_NC_RD;
                        mlfqs_pkg::OP_CHILD: state_next = mlfqs_pkg::S_CH_RD;
                        default:             state_next = mlfqs_pkg::S_RO_RD;
                    endcase
                end
            end
            mlfqs_pkg::S_TK_RD:  state_next = mlfqs_pkg::S_TK_WR;
            mlfqs_pkg::S_TK_WR:  state_next = mlfqs_pkg::S_MOD_GO;
            mlfqs_pkg::S_MOD_GO: state_next = mlfqs_pkg::S_MOD_WAIT;
            mlfqs_pkg::S_MOD_WAIT:
                if (div_cnt_reg == 7'd0) begin
                    if (div_rem_reg == 35'd0 && tc_reg != 64'd0)
                        state_next = mlfqs_pkg::S_LA1_GO;
                    else
                        state_next = mlfqs_pkg::S_SLICE_CHK;
                end
            mlfqs_pkg::S_LA1_GO: state_next = mlfqs_pkg::S_LA1_WAIT;
            mlfqs_pkg::S_LA1_WAIT:
                if (div_cnt_reg == 7'd0) state_next = mlfqs_pkg::S_LA2_GO;
            mlfqs_pkg::S_LA2_GO: state_next = mlfqs_pkg::S_LA2_WAIT;
            mlfqs_pkg::S_LA2_WAIT:
                if (div_cnt_reg == 7'd0) state_next = mlfqs_pkg::S_CO_GO;
            mlfqs_pkg::S_CO_GO: state_next = mlfqs_pkg::S_CO_WAIT;
            mlfqs_pkg::S_CO_WAIT:
                if (div_cnt_reg == 7'd0) state_next = mlfqs_pkg::S_DC_RD;
            mlfqs_pkg::S_DC_RD:  state_next = mlfqs_pkg::S_DC_MUL;
            mlfqs_pkg::S_DC_MUL: state_next = mlfqs_pkg::S_DC_WR;
            mlfqs_pkg::S_DC_WR:
                state_next = idx_last ? mlfqs_pkg::S_SLICE_CHK : mlfqs_pkg::S_DC_RD;
            mlfqs_pkg::S_SLICE_CHK:
                state_next = (tc_reg[mlfqs_pkg::SLICE_W-1:0] == '0) ?
                             mlfqs_pkg::S_PR_RD : mlfqs_pkg::S_RO_RD;
            mlfqs_pkg::S_PR_RD: state_next = mlfqs_pkg::S_PR_WR;
            mlfqs_pkg::S_PR_WR:
                state_next = idx_last ? mlfqs_pkg::S_RO_RD : mlfqs_pkg::S_PR_RD;
            mlfqs_pkg::S_NC_RD:  state_next = mlfqs_pkg::S_NC_WR;
            mlfqs_pkg::S_NC_WR:  state_next = mlfqs_pkg::S_RO_RD;
            mlfqs_pkg::S_CH_RD:  state_next = mlfqs_pkg::S_CH_WR;
            mlfqs_pkg::S_CH_WR:  state_next = mlfqs_pkg::S_RO_RD;
            mlfqs_pkg::S_RO_RD:  state_next = mlfqs_pkg::S_RO_MUL;
            mlfqs_pkg::S_RO_MUL: state_next = mlfqs_pkg::S_RO_OUT;
            mlfqs_pkg::S_RO_OUT:
                if (out_free) state_next = mlfqs_pkg::S_IDLE;
            default: state_next = mlfqs_pkg::S_IDLE;
        endcase
    end

    // Table port, divider operands and row updates.
    always_comb begin
        logic signed [33:0] b;
        logic signed [33:0] c;
        logic signed [47:0] pr;
        re = 1'b0;
        we = 1'b0;
        ra = tid_reg;
        wa = tid_reg;
        wd = row;
        div_start = 1'b0;
        div_a = '0;
        div_b = '0;
        pr = prod_reg + ((prod_reg < 0) ? 48'sd16383 : 48'sd0);
        b = 34'(pr >>> mlfqs_pkg::FP_SHIFT);
        c = 34'(row.nice) <<< mlfqs_pkg::FP_SHIFT;
        unique case (state_reg)
            mlfqs_pkg::S_TK_RD, mlfqs_pkg::S_NC_RD, mlfqs_pkg::S_RO_RD: re = 1'b1;
            mlfqs_pkg::S_CH_RD: begin
                re = 1'b1;
                ra = pid_reg;
            end
            mlfqs_pkg::S_DC_RD, mlfqs_pkg::S_PR_RD: begin
                re = 1'b1;
                ra = idx_reg[TW-1:0];
            end
            mlfqs_pkg::S_TK_WR: begin
                we = 1'b1;
                wd.rc = sat32(35'(row.rc) + 35'sd16384);
            end
            mlfqs_pkg::S_DC_WR: begin
                we = 1'b1;
                wa = idx_reg[TW-1:0];
                wd.rc = sat32(35'(b) + 35'(c));
            end
            mlfqs_pkg::S_PR_WR: begin
                we = 1'b1;
                wa = idx_reg[TW-1:0];
                wd.pri = pri_calc(row.rc, row.nice, pmax_reg, pmin_reg);
            end
            mlfqs_pkg::S_NC_WR: begin
                we = 1'b1;
                wd.nice = nv_reg;
                wd.pri = pri_calc(row.rc, nv_reg, pmax_reg, pmin_reg);
            end
            mlfqs_pkg::S_CH_WR: begin
                we = 1'b1;
                wd.pri = sp_reg;
            end
            mlfqs_pkg::S_MOD_GO: begin
                div_start = 1'b1;
                div_a = tc_reg;
                div_b = 34'(tps_eff);
            end
            mlfqs_pkg::S_CO_GO: begin
                div_start = 1'b1;
                div_a = 64'(la_reg) << (mlfqs_pkg::FP_SHIFT + 1);
                div_b = (34'(la_reg) << 1) + (34'd1 << mlfqs_pkg::FP_SHIFT);
            end
            default: ;
        endcase
    end

    assign div_trial = {div_rem_reg[33:0], div_quo_reg[63]};
    assign div_ge    = (div_trial >= {1'b0, div_den_reg});

    always_ff @(posedge aclk) begin
        if (we) row_mem[wa] <= wd;
        if (re) rd_raw_reg <= row_mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (we) vld_reg[wa] <= 1'b1;
            if (re) rd_vld_reg <= vld_reg[ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mlfqs_pkg::S_IDLE;
            tc_reg       <= '0;
            la_reg       <= '0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_tvalid && s_tready && mlfqs_pkg::op_t'(s_tdata[1:0]) == mlfqs_pkg::OP_TICK)
                tc_reg <= tc_reg + 64'd1;
            if (div_start) begin
                div_cnt_reg <= 7'(mlfqs_pkg::DIV_STEPS);
            end else if (div_cnt_reg != 7'd0) begin
                div_cnt_reg <= div_cnt_reg - 7'd1;
            end
            if (state_reg == mlfqs_pkg::S_LA2_WAIT) begin
                // The load average never goes negative, so only the top needs a clamp.
                la_reg <= sat32(35'(q1_reg) + 35'(rcp_q));
            end
            if (state_reg == mlfqs_pkg::S_RO_OUT && out_free) m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        logic [38:0] mag;
        logic [24:0] rc_out;
        logic [38:0] la_rnd;
        if (s_tvalid && s_tready) begin
            tid_reg <= s_tdata[7:2];
            pid_reg <= s_tdata[13:8];
            nv_reg  <= s_tdata[19:14];
            sp_reg  <= s_tdata[25:20];
            rdy_reg <= s_tdata[33:27];
        end
        if (div_start) begin
            div_rem_reg <= '0;
            div_quo_reg <= div_a;
            div_den_reg <= div_b;
        end else if (div_cnt_reg != 7'd0) begin
            div_rem_reg <= div_ge ? (div_trial - {1'b0, div_den_reg}) : div_trial;
            div_quo_reg <= {div_quo_reg[62:0], div_ge};
        end
        if (state_reg == mlfqs_pkg::S_LA1_WAIT)
            q1_reg <= 32'(rcp_q);
        if (state_reg == mlfqs_pkg::S_CO_WAIT && div_cnt_reg == 7'd0)
            coef_reg <= div_quo_reg[14:0];
        if (state_reg == mlfqs_pkg::S_CO_WAIT || state_reg == mlfqs_pkg::S_SLICE_CHK)
            idx_reg <= '0;
        else if (state_reg == mlfqs_pkg::S_DC_WR || state_reg == mlfqs_pkg::S_PR_WR)
            idx_reg <= idx_reg + 1'b1;
        if (state_reg == mlfqs_pkg::S_DC_MUL)
            prod_reg <= $signed({1'b0, coef_reg}) * row.rc;
        if (state_reg == mlfqs_pkg::S_RO_MUL) begin
            rc100_reg <= 39'(row.rc) * 39'sd100;
            la100_reg <= 39'(la_reg) * 39'd100;
        end
        if (state_reg == mlfqs_pkg::S_RO_OUT && out_free) begin
            // Round half away from zero: work on the magnitude, then restore the sign.
            mag = (rc100_reg < 0) ? 39'(-rc100_reg) : 39'(rc100_reg);
            mag = (mag + 39'd8192) >> mlfqs_pkg::FP_SHIFT;
            rc_out = (rc100_reg < 0) ? 25'(-mag) : mag[24:0];
            la_rnd = (la100_reg + 39'd8192) >> mlfqs_pkg::FP_SHIFT;
            m_tdata_reg <= {6'd0,
                            en_reg ? la_rnd[12:0] : 13'd0,
                            en_reg ? rc_out : 25'd0,
                            en_reg ? row.nice : 6'sd0,
                            row.pri};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mlfqs_pkg::S_IDLE) |-> (div_cnt_reg == 7'd0))
        else $error("divider busy while sequencer idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == mlfqs_pkg::S_RO_OUT))
        else $error("result raised outside readout");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (re && we) |-> 1'b0)
        else $error("table read and write in one cycle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mlfqs_pkg::S_DC_WR || state_reg == mlfqs_pkg::S_PR_WR)
        |-> (idx_reg < (TW+1)'(mlfqs_pkg::THREADS)))
        else $error("sweep index out of range");

endmodule
`default_nettype wire

>>> verif/tb_mlfqs_priority_engine.sv
// Self-checking testbench for mlfqs_priority_engine: directed and random stream traffic,
// APB register phases and a cycle-free predictor of the thread tables.
// Depends on mlfqs_pkg and the engine top level.
`timescale 1ns / 1ps
module tb_mlfqs_priority_engine;

    localparam longint ONE_FP = 16384;

    typedef struct {
        mlfqs_pkg::op_t op;
        logic [5:0]  tid;
        logic [5:0]  pid;
        logic [5:0]  nice;
        logic [5:0]  start_pri;
        logic        active;
        logic [6:0]  ready;
    } sched_req_t;

    typedef struct {
        logic [5:0]  pri;
        logic [5:0]  nice;
        logic [24:0] rc_x100;
        logic [12:0] la_x100;
    } thread_view_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mlfqs_priority_engine dut (.*);

    initial forever #5 aclk = ~aclk;

    // Predictor copy of the engine state and its registers.
    logic                 sched_on;
    logic [5:0]           top_pri, floor_pri;
    logic [9:0]           tps_reg;
    logic signed [31:0]   cpu_tab [mlfqs_pkg::THREADS];
    logic signed [5:0]    nice_tab [mlfqs_pkg::THREADS];
    logic [5:0]           pri_tab [mlfqs_pkg::THREADS];
    logic signed [31:0]   load_fp;
    longint unsigned      tick_total;

    sched_req_t   pending_q [$];
    thread_view_t expected_q [$];
    sched_req_t   cur_req;
    int           fail_cnt = 0, checked_cnt = 0, tick_reqs = 0;
    int unsigned  cyc = 0;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint scaled_x100(longint v);
        longint s = 100 * v;
        return (v >= 0) ? (s + ONE_FP / 2) / ONE_FP : (s - ONE_FP / 2) / ONE_FP;
    endfunction

    function automatic void refresh_priority(int t);
        longint a, pri;
        a = (longint'(cpu_tab[t]) / 4) / ONE_FP;
        pri = longint'(top_pri) - a - 2 * longint'(nice_tab[t]);
        if (pri > longint'(top_pri)) pri = top_pri;
        else if (pri < longint'(floor_pri)) pri = floor_pri;
        pri_tab[t] = pri[5:0];
    endfunction

    function automatic void decay_second(logic [6:0] ready);
        longint r, la, coef, b;
        r = (ready > mlfqs_pkg::THREADS) ? mlfqs_pkg::THREADS : ready;
        la = (59 * longint'(load_fp)) / 60 + (r * ONE_FP) / 60;
        load_fp = 32'(clip32(la));
        la = (load_fp < 0) ? 0 : load_fp;
        coef = (2 * la * ONE_FP) / (2 * la + ONE_FP);
        for (int i = 0; i < mlfqs_pkg::THREADS; i++) begin
            b = (coef * longint'(cpu_tab[i])) / ONE_FP;
            cpu_tab[i] = 32'(clip32(b + longint'(nice_tab[i]) * ONE_FP));
        end
    endfunction

    function automatic thread_view_t apply_request(sched_req_t q);
        thread_view_t v;
        longint rc, la;
        int t = q.tid;
        int unsigned per;
        case (q.op)
            mlfqs_pkg::OP_TICK: begin
                tick_total++;
                if (sched_on) begin
                    per = (tps_reg == 0) ? 1 : tps_reg;
                    if (q.active)
                        cpu_tab[t] = 32'(clip32(longint'(cpu_tab[t]) + ONE_FP));
                    if (tick_total % per == 0) decay_second(q.ready);
                    if (tick_total % 4 == 0)
                        for (int i = 0; i < mlfqs_pkg::THREADS; i++) refresh_priority(i);
                end
            end
            mlfqs_pkg::OP_NICE: begin
                nice_tab[t] = q.nice;
                refresh_priority(t);
            end
            mlfqs_pkg::OP_CHILD: begin
                nice_tab[t] = nice_tab[q.pid];
                cpu_tab[t] = cpu_tab[q.pid];
                pri_tab[t] = q.start_pri;
            end
            default: ;
        endcase
        v.pri = pri_tab[t];
        if (sched_on) begin
            rc = scaled_x100(cpu_tab[t]);
            la = scaled_x100(load_fp);
            v.nice = nice_tab[t];
            v.rc_x100 = rc[24:0];
            v.la_x100 = la[12:0];
        end else begin
            v.nice = '0;
            v.rc_x100 = '0;
            v.la_x100 = '0;
        end
        return v;
    endfunction

    function automatic logic [39:0] pack_request(sched_req_t q);
        return {6'b0, q.ready, q.active, q.start_pri, q.nice, q.pid, q.tid, q.op};
    endfunction

    // Stretches with no idle cycles keep both sides streaming; elsewhere idles come at random.
    function automatic logic want_idle();
        if (cyc % 3000 < 700) return 1'b0;
        return $urandom_range(0, 99) < 31;
    endfunction

    always @(posedge aclk) cyc <= cyc + 1;

    // Request driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_q.push_back(apply_request(cur_req));
                if (cur_req.op == mlfqs_pkg::OP_TICK) tick_reqs++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() > 0 && !want_idle()) begin
                    cur_req = pending_q.pop_front();
                    s_tdata <= pack_request(cur_req);
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        thread_view_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !want_idle();
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request outstanding: %h", m_tdata);
                    fail_cnt++;
                end else begin
                    e = expected_q.pop_front();
                    checked_cnt++;
                    if (m_tdata[5:0] !== e.pri) begin
                        $error("priority_res exp %0d got %0d", e.pri, m_tdata[5:0]);
                        fail_cnt++;
                    end
                    if (m_tdata[11:6] !== e.nice) begin
                        $error("nice_out exp %0d got %0d", $signed(e.nice),
                               $signed(m_tdata[11:6]));
                        fail_cnt++;
                    end
                    if (m_tdata[36:12] !== e.rc_x100) begin
                        $error("recent_cpu_x100 exp %0d got %0d", $signed(e.rc_x100),
                               $signed(m_tdata[36:12]));
                        fail_cnt++;
                    end
                    if (m_tdata[49:37] !== e.la_x100) begin
                        $error("load_avg_x100 exp %0d got %0d", e.la_x100,
                               m_tdata[49:37]);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    task automatic reg_write(mlfqs_pkg::reg_idx_t r, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 4'(r) << 2;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            mlfqs_pkg::REG_ENABLE:  sched_on = val[0];
            mlfqs_pkg::REG_PRI_MAX: top_pri = val[5:0];
            mlfqs_pkg::REG_PRI_MIN: floor_pri = val[5:0];
            mlfqs_pkg::REG_TPS:     tps_reg = val[9:0];
            default: ;
        endcase
    endtask

    task automatic set_policy(logic en, logic [5:0] hi, logic [5:0] lo, logic [9:0] tps);
        reg_write(mlfqs_pkg::REG_ENABLE, 32'(en));
        reg_write(mlfqs_pkg::REG_PRI_MAX, 32'(hi));
        reg_write(mlfqs_pkg::REG_PRI_MIN, 32'(lo));
        reg_write(mlfqs_pkg::REG_TPS, 32'(tps));
    endtask

    task automatic push_req(mlfqs_pkg::op_t op, int tid, int pid, int nice, int sp, bit act,
                            int ready);
        sched_req_t q;
        q.op = op;
        q.tid = 6'(tid);
        q.pid = 6'(pid);
        q.nice = 6'(nice);
        q.start_pri = 6'(sp);
        q.active = act;
        q.ready = 7'(ready);
        pending_q.push_back(q);
    endtask

    task automatic push_random(int n);
        sched_req_t q;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            q.op = (k < 50) ? mlfqs_pkg::OP_TICK : (k < 65) ? mlfqs_pkg::OP_NICE :
                   (k < 80) ? mlfqs_pkg::OP_CHILD : mlfqs_pkg::OP_READ;
            // Half the requests go to four hot threads, 0 to 3, which accumulate CPU usage; the rest are spread out.
            q.tid = $urandom_range(0, 1) ? 6'($urandom_range(0, 3)) : 6'($urandom);
            q.pid = $urandom_range(0, 1) ? 6'($urandom_range(0, 3)) : 6'($urandom);
            q.nice = $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, 40) - 20);
            q.start_pri = 6'($urandom);
            q.active = $urandom_range(0, 99) < 80;
            q.ready = 7'($urandom);
            pending_q.push_back(q);
        end
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        sched_on = 0;
        top_pri = 63;
        floor_pri = 0;
        tps_reg = 100;
        foreach (cpu_tab[i]) begin
            cpu_tab[i] = 0;
            nice_tab[i] = 0;
            pri_tab[i] = 0;
        end
        load_fp = 0;
        tick_total = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Scheduler off: ticks only count, set nice still recomputes.
        push_req(mlfqs_pkg::OP_TICK, 5, 0, 0, 0, 1, 64);
        push_req(mlfqs_pkg::OP_NICE, 63, 0, -20, 0, 0, 0);
        push_req(mlfqs_pkg::OP_CHILD, 0, 63, 0, 63, 0, 0);
        push_req(mlfqs_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
        push_req(mlfqs_pkg::OP_TICK, 0, 0, 0, 0, 1, 0);
        drain();

        set_policy(1, 63, 0, 1);
        push_req(mlfqs_pkg::OP_NICE, 1, 0, 20, 0, 0, 0);
        push_req(mlfqs_pkg::OP_NICE, 2, 0, -32, 0, 0, 0);
        push_req(mlfqs_pkg::OP_NICE, 3, 0, 31, 0, 0, 0);
        push_req(mlfqs_pkg::OP_TICK, 1, 0, 0, 0, 1, 0);
        push_req(mlfqs_pkg::OP_TICK, 2, 0, 0, 0, 1, 64);
        push_req(mlfqs_pkg::OP_TICK, 3, 0, 0, 0, 0, 127);
        push_req(mlfqs_pkg::OP_TICK, 0, 0, 0, 0, 1, 100);
        push_req(mlfqs_pkg::OP_CHILD, 4, 4, 0, 17, 0, 0);
        push_req(mlfqs_pkg::OP_CHILD, 10, 1, 0, 0, 1, 0);
        push_req(mlfqs_pkg::OP_CHILD, 63, 2, 0, 63, 0, 0);
        push_req(mlfqs_pkg::OP_READ, 63, 0, 0, 0, 0, 0);
        push_req(mlfqs_pkg::OP_TICK, 63, 63, 31, 63, 1, 1);
        push_req(mlfqs_pkg::OP_READ, 1, 0, 0, 0, 0, 0);
        drain();

        set_policy(1, 63, 0, 3);
        push_random(25);
        drain();
        // Lower clamp above the upper one.
        set_policy(1, 40, 50, 2);
        push_random(20);
        drain();
        set_policy(1, 0, 0, 0);
        push_random(20);
        drain();
        set_policy(1, 63, 63, 1000);
        push_random(17);
        drain();
        set_policy(1, 31, 5, 1);
        push_random(20);
        drain();
        set_policy(0, 63, 0, 100);
        push_random(20);
        drain();

        $display("Covered %0d tick requests among %0d checked results over eight policies.",
                 tick_reqs, checked_cnt);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timed out with %0d requests still outstanding.", expected_q.size());
        $display("Test completed with failures");
        $finish;
    end
endmodule
